FILE: sv/mdio_master_indirect_access_defines.svh
// assertion macros shared by the mdio master checker
`ifndef MDIO_MASTER_INDIRECT_ACCESS_DEFINES_SVH
`define MDIO_MASTER_INDIRECT_ACCESS_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MMIA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MMIA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mmia_pkg.sv
// constants and frame selection functions for the mdio clause 22 master
`default_nettype none
package mmia_pkg;

  localparam logic [1:0] OP_RD_DIRECT = 2'd0;
  localparam logic [1:0] OP_WR_DIRECT = 2'd1;
  localparam logic [1:0] OP_RD_INDIR  = 2'd2;
  localparam logic [1:0] OP_WR_INDIR  = 2'd3;

  localparam int unsigned CNT_W = 6;
  localparam logic [CNT_W-1:0] PREAMBLE_BITS = 6'd32;
  localparam logic [CNT_W-1:0] DATA_BITS     = 6'd16;
  localparam logic [CNT_W-1:0] FLUSH_TICKS   = 6'd32;
  localparam logic [CNT_W-1:0] START_BITS    = 6'd4;
  localparam logic [CNT_W-1:0] ADDR_BITS     = 6'd5;
  localparam logic [CNT_W-1:0] TA_BITS       = 6'd2;

  // start 01 followed by opcode
  localparam logic [3:0] START_RD = 4'b0110;
  localparam logic [3:0] START_WR = 4'b0101;

  localparam logic [4:0] REG_PAGE  = 5'd31;
  localparam logic [4:0] REG_ADDR  = 5'd23;
  localparam logic [4:0] REG_CTRL  = 5'd21;
  localparam logic [4:0] REG_RDATA = 5'd25;
  localparam logic [4:0] REG_WDATA = 5'd24;

  localparam logic [15:0] VAL_PAGE   = 16'h000E;
  localparam logic [15:0] VAL_RD_CMD = 16'h0001;
  localparam logic [15:0] VAL_WR_CMD = 16'h0003;
  localparam logic [15:0] VAL_FAIL   = 16'hFFFF;

  function automatic logic is_direct(input logic [1:0] op);
    return (op == OP_RD_DIRECT) || (op == OP_WR_DIRECT);
  endfunction

  function automatic logic frame_reads(input logic [1:0] op, input logic [1:0] idx);
    return (op == OP_RD_DIRECT) || ((op == OP_RD_INDIR) && (idx == 2'd3));
  endfunction

  function automatic logic frame_last(input logic [1:0] op, input logic [1:0] idx);
    return is_direct(op) ? (idx == 2'd0) : (idx == 2'd3);
  endfunction

  function automatic logic [4:0] frame_reg(input logic [1:0] op, input logic [1:0] idx,
                                           input logic [15:0] addr);
    logic [4:0] r;
    if (is_direct(op)) begin
      r = addr[4:0];
    end else begin
      case (idx)
        2'd0:    r = REG_PAGE;
        2'd1:    r = REG_ADDR;
        2'd2:    r = (op == OP_RD_INDIR) ? REG_CTRL : REG_WDATA;
        default: r = (op == OP_RD_INDIR) ? REG_RDATA : REG_CTRL;
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] frame_wdata(input logic [1:0] op, input logic [1:0] idx,
                                              input logic [15:0] addr,
                                              input logic [15:0] data);
    logic [15:0] d;
    if (is_direct(op)) begin
      d = data;
    end else begin
      case (idx)
        2'd0:    d = VAL_PAGE;
        2'd1:    d = addr;
        2'd2:    d = (op == OP_RD_INDIR) ? VAL_RD_CMD : data;
        default: d = VAL_WR_CMD;
      endcase
    end
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: sv/mdio_master_indirect_access.sv
// mdio clause 22 master with indirect paged access, one mdc bit per tick
// each result is loaded into the output register in the cycle after its item is accepted
// throughput: one item per cycle while in_stall is low; frame state and result register update together
// in_stall rises only while a result is held and out_stall is high
// reset (rst_n low, synchronous): idle, not busy, counters and output valid cleared
`default_nettype none
module mdio_master_indirect_access (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [1:0]  in_op,
  input  wire logic [4:0]  in_phy_addr,
  input  wire logic [15:0] in_reg_addr,
  input  wire logic [15:0] in_wr_data,
  input  wire logic        in_mdio_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_mdio_level,
  output logic             out_mdio_drive,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic [15:0]      out_read_value,
  output logic             out_ta_error,
  output logic             out_cmd_rejected
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_PRE   = 4'd1;
  localparam logic [3:0] PH_START = 4'd2;
  localparam logic [3:0] PH_PHY   = 4'd3;
  localparam logic [3:0] PH_REG   = 4'd4;
  localparam logic [3:0] PH_TAW   = 4'd5;
  localparam logic [3:0] PH_WDATA = 4'd6;
  localparam logic [3:0] PH_WIDLE = 4'd7;
  localparam logic [3:0] PH_TAR   = 4'd8;
  localparam logic [3:0] PH_RDATA = 4'd9;
  localparam logic [3:0] PH_RIDLE = 4'd10;
  localparam logic [3:0] PH_FLUSH = 4'd11;

  localparam int unsigned CW = mmia_pkg::CNT_W;

  logic [3:0]    phase_r, phase_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic [1:0]    fidx_r, fidx_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [4:0]    phy_r, phy_nxt;
  logic [15:0]   reg_r, reg_nxt;
  logic [15:0]   data_r, data_nxt;
  logic [15:0]   shift_r, shift_nxt;
  logic [15:0]   cap_r, cap_nxt;
  logic          busy_r, busy_nxt;
  logic          err_r, err_nxt;

  logic          ov_r, ov_nxt;
  logic          mdio_level_r, mdio_drive_r, busy_res_r, done_r, terr_r, rej_r;
  logic [15:0]   rval_r;

  logic          accept;
  logic          drv, lvl, done, terr, rej, end_frame, rd, last;
  logic [15:0]   rval;
  logic [CW-1:0] bc_inc;
  logic [3:0]    start_code;
  logic [4:0]    cur_reg;
  logic [2:0]    addr_idx;

  assign in_stall = ov_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign bc_inc     = bc_r + {{(CW-1){1'b0}}, 1'b1};
  assign rd         = mmia_pkg::frame_reads(op_r, fidx_r);
  assign last       = mmia_pkg::frame_last(op_r, fidx_r);
  assign start_code = rd ? mmia_pkg::START_RD : mmia_pkg::START_WR;
  assign cur_reg    = mmia_pkg::frame_reg(op_r, fidx_r, reg_r);
  assign addr_idx   = 3'd4 - bc_r[2:0];

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    fidx_nxt  = fidx_r;
    op_nxt    = op_r;
    phy_nxt   = phy_r;
    reg_nxt   = reg_r;
    data_nxt  = data_r;
    shift_nxt = shift_r;
    cap_nxt   = cap_r;
    busy_nxt  = busy_r;
    err_nxt   = err_r;
    drv       = 1'b0;
    lvl       = 1'b0;
    done      = 1'b0;
    rval      = 16'd0;
    terr      = 1'b0;
    rej       = 1'b0;
    end_frame = 1'b0;

    if (!in_req_type) begin
      if (busy_r) begin
        rej = 1'b1;
      end else begin
        op_nxt    = in_op;
        phy_nxt   = in_phy_addr;
        reg_nxt   = in_reg_addr;
        data_nxt  = in_wr_data;
        fidx_nxt  = 2'd0;
        busy_nxt  = 1'b1;
        phase_nxt = PH_PRE;
        bc_nxt    = '0;
        err_nxt   = 1'b0;
        cap_nxt   = 16'd0;
        shift_nxt = mmia_pkg::frame_wdata(in_op, 2'd0, in_reg_addr, in_wr_data);
      end
    end else if (busy_r) begin
      unique case (phase_r)
        PH_PRE: begin
          drv    = 1'b1;
          lvl    = 1'b1;
          bc_nxt = bc_inc;
          if (bc_inc >= mmia_pkg::PREAMBLE_BITS) begin
            phase_nxt = PH_START;
            bc_nxt    = '0;
          end
        end
        PH_START: begin
          drv    = 1'b1;
          lvl    = start_code[2'd3 - bc_r[1:0]];
          bc_nxt = bc_inc;
          if (bc_inc >= mmia_pkg::START_BITS) begin
            phase_nxt = PH_PHY;
            bc_nxt    = '0;
          end
        end
        PH_PHY: begin
          drv    = 1'b1;
          lvl    = phy_r[addr_idx];
          bc_nxt = bc_inc;
          if (bc_inc >= mmia_pkg::ADDR_BITS) begin
            phase_nxt = PH_REG;
            bc_nxt    = '0;
          end
        end
        PH_REG: begin
          drv    = 1'b1;
          lvl    = cur_reg[addr_idx];
          bc_nxt = bc_inc;
          if (bc_inc >= mmia_pkg::ADDR_BITS) begin
            phase_nxt = rd ? PH_TAR : PH_TAW;
            bc_nxt    = '0;
          end
        end
        PH_TAW: begin
          drv    = 1'b1;
          lvl    = (bc_r == '0);
          bc_nxt = bc_inc;
          if (bc_inc >= mmia_pkg::TA_BITS) begin
            phase_nxt = PH_WDATA;
            bc_nxt    = '0;
          end
        end
        PH_WDATA: begin
          drv       = 1'b1;
          lvl       = shift_r[15];
          shift_nxt = {shift_r[14:0], 1'b0};
          bc_nxt    = bc_inc;
          if (bc_inc >= mmia_pkg::DATA_BITS) begin
            phase_nxt = PH_WIDLE;
            bc_nxt    = '0;
          end
        end
        PH_WIDLE: begin
          drv       = 1'b1;
          lvl       = 1'b1;
          end_frame = 1'b1;
        end
        PH_TAR: begin
          bc_nxt = '0;
          if (in_mdio_in) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_FLUSH;
          end else begin
            cap_nxt   = 16'd0;
            phase_nxt = PH_RDATA;
          end
        end
        PH_FLUSH: begin
          bc_nxt = bc_inc;
          if (bc_inc >= mmia_pkg::FLUSH_TICKS) begin
            cap_nxt   = mmia_pkg::VAL_FAIL;
            end_frame = 1'b1;
          end
        end
        PH_RDATA: begin
          cap_nxt = {cap_r[14:0], in_mdio_in};
          bc_nxt  = bc_inc;
          if (bc_inc >= mmia_pkg::DATA_BITS) begin
            phase_nxt = PH_RIDLE;
            bc_nxt    = '0;
          end
        end
        PH_RIDLE: begin
          end_frame = 1'b1;
        end
        default: begin
          // no valid phase while busy: drop the transaction
          phase_nxt = PH_IDLE;
          busy_nxt  = 1'b0;
        end
      endcase

      if (end_frame) begin
        if (last) begin
          done      = 1'b1;
          rval      = rd ? cap_nxt : 16'd0;
          terr      = err_nxt;
          busy_nxt  = 1'b0;
          phase_nxt = PH_IDLE;
          bc_nxt    = '0;
        end else begin
          fidx_nxt  = fidx_r + 2'd1;
          phase_nxt = PH_PRE;
          bc_nxt    = '0;
          err_nxt   = 1'b0;
          cap_nxt   = 16'd0;
          shift_nxt = mmia_pkg::frame_wdata(op_r, fidx_r + 2'd1, reg_r, data_r);
        end
      end
    end
  end

  assign ov_nxt = accept ? 1'b1 : (ov_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bc_r    <= '0;
      fidx_r  <= 2'd0;
      op_r    <= 2'd0;
      phy_r   <= 5'd0;
      reg_r   <= 16'd0;
      data_r  <= 16'd0;
      shift_r <= 16'd0;
      cap_r   <= 16'd0;
      busy_r  <= 1'b0;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
        bc_r    <= bc_nxt;
        fidx_r  <= fidx_nxt;
        op_r    <= op_nxt;
        phy_r   <= phy_nxt;
        reg_r   <= reg_nxt;
        data_r  <= data_nxt;
        shift_r <= shift_nxt;
        cap_r   <= cap_nxt;
        busy_r  <= busy_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  // result register, loaded once per accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      mdio_level_r <= drv & lvl;
      mdio_drive_r <= drv;
      busy_res_r   <= busy_nxt;
      done_r       <= done;
      rval_r       <= rval;
      terr_r       <= terr;
      rej_r        <= rej;
    end
  end

  assign out_valid        = ov_r;
  assign out_mdio_level   = mdio_level_r;
  assign out_mdio_drive   = mdio_drive_r;
  assign out_busy_res     = busy_res_r;
  assign out_done_res     = done_r;
  assign out_read_value   = rval_r;
  assign out_ta_error     = terr_r;
  assign out_cmd_rejected = rej_r;

endmodule
`default_nettype wire

FILE: sv/mmia_checker.sv
// port-level checker for the mdio master and its bind
`default_nettype none
`include "mdio_master_indirect_access_defines.svh"
module mmia_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_mdio_level,
  input wire logic        out_mdio_drive,
  input wire logic        out_busy_res,
  input wire logic        out_done_res,
  input wire logic [15:0] out_read_value,
  input wire logic        out_ta_error,
  input wire logic        out_cmd_rejected
);

  // a held result stays until it is transferred
  `MMIA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")

  // released line never shows a high level
  `MMIA_ASSERT_IMP(a_release_low, out_valid && !out_mdio_drive, !out_mdio_level, "high level")

  // read data and error only with done
  `MMIA_ASSERT_IMP(a_done_fields, out_valid && !out_done_res, !(|out_read_value), "read data")
  `MMIA_ASSERT_IMP(a_done_error, out_valid && !out_done_res, !out_ta_error, "ta error")

  // a rejected command leaves the transaction running and drives nothing
  `MMIA_ASSERT_IMP(a_reject, out_valid && out_cmd_rejected, out_busy_res && !out_mdio_drive && !out_done_res, "bad reject")

endmodule

bind mdio_master_indirect_access mmia_checker u_mmia_checker (.*);
`default_nettype wire

FILE: verif/mdio_master_indirect_access_test.sv
// testbench for the mdio clause 22 master with a predicting scoreboard
`timescale 1ns / 1ps
module mdio_master_indirect_access_test;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;
  localparam int MDIN_RANDOM = 2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PREAMBLE, PH_START, PH_PHY, PH_REGADR, PH_TA_WR, PH_WDATA,
    PH_WIDLE, PH_TA_RD, PH_RDATA, PH_RIDLE, PH_FLUSH
  } frame_phase_t;

  typedef struct {
    logic        req_type;
    logic [1:0]  op;
    logic [4:0]  phy;
    logic [15:0] reg_addr;
    logic [15:0] wr_data;
    logic        mdio_in;
  } mdio_item_t;

  typedef struct packed {
    logic        mdio_level;
    logic        mdio_drive;
    logic        busy;
    logic        done;
    logic [15:0] read_value;
    logic        ta_error;
    logic        rejected;
  } mdio_result_t;

  class mdio_frame_scoreboard;
    frame_phase_t phase;
    logic [5:0]   cnt;
    logic [1:0]   idx;
    logic [1:0]   op;
    logic [4:0]   phy;
    logic [15:0]  addr;
    logic [15:0]  wdata;
    logic [15:0]  shreg;
    logic [15:0]  capture;
    logic         busy;
    logic         err;
    // what the current frame addresses and whether it reads
    logic [4:0]   f_reg;
    logic         f_rd;
    logic         f_last;
    mdio_result_t due_results[$];
    int           errors;
    int           seen;

    function new();
      phase = PH_IDLE;
      cnt = '0;
      idx = '0;
      op = '0;
      phy = '0;
      addr = '0;
      wdata = '0;
      shreg = '0;
      capture = '0;
      busy = 1'b0;
      err = 1'b0;
      f_reg = '0;
      f_rd = 1'b0;
      f_last = 1'b0;
      errors = 0;
      seen = 0;
    endfunction

    function void start_frame();
      logic direct;
      direct = (op == mmia_pkg::OP_RD_DIRECT) || (op == mmia_pkg::OP_WR_DIRECT);
      phase = PH_PREAMBLE;
      cnt = '0;
      err = 1'b0;
      capture = '0;
      f_rd = 1'b0;
      if (direct) begin
        f_reg = addr[4:0];
        shreg = wdata;
        f_rd = (op == mmia_pkg::OP_RD_DIRECT);
      end else begin
        case (idx)
          2'd0: begin
            f_reg = mmia_pkg::REG_PAGE;
            shreg = mmia_pkg::VAL_PAGE;
          end
          2'd1: begin
            f_reg = mmia_pkg::REG_ADDR;
            shreg = addr;
          end
          2'd2: begin
            f_reg = (op == mmia_pkg::OP_RD_INDIR) ? mmia_pkg::REG_CTRL : mmia_pkg::REG_WDATA;
            shreg = (op == mmia_pkg::OP_RD_INDIR) ? mmia_pkg::VAL_RD_CMD : wdata;
          end
          default: begin
            f_reg = (op == mmia_pkg::OP_RD_INDIR) ? mmia_pkg::REG_RDATA : mmia_pkg::REG_CTRL;
            shreg = mmia_pkg::VAL_WR_CMD;
            f_rd = (op == mmia_pkg::OP_RD_INDIR);
          end
        endcase
      end
      f_last = direct || (idx == 2'd3);
    endfunction

    function mdio_result_t predict_tick(mdio_item_t it);
      mdio_result_t r;
      logic drv;
      logic lvl;
      logic fin;
      logic [3:0] code;
      r = '0;
      drv = 1'b0;
      lvl = 1'b0;
      fin = 1'b0;
      if (it.req_type == REQ_CMD) begin
        if (busy) begin
          r.rejected = 1'b1;
        end else begin
          op = it.op;
          phy = it.phy;
          addr = it.reg_addr;
          wdata = it.wr_data;
          idx = '0;
          busy = 1'b1;
          start_frame();
        end
      end else if (busy) begin
        case (phase)
          PH_PREAMBLE: begin
            drv = 1'b1;
            lvl = 1'b1;
            cnt++;
            if (cnt >= mmia_pkg::PREAMBLE_BITS) begin
              phase = PH_START;
              cnt = '0;
            end
          end
          PH_START: begin
            code = f_rd ? mmia_pkg::START_RD : mmia_pkg::START_WR;
            drv = 1'b1;
            lvl = code[2'd3 - cnt[1:0]];
            cnt++;
            if (cnt >= mmia_pkg::START_BITS) begin
              phase = PH_PHY;
              cnt = '0;
            end
          end
          PH_PHY: begin
            drv = 1'b1;
            lvl = phy[3'd4 - cnt[2:0]];
            cnt++;
            if (cnt >= mmia_pkg::ADDR_BITS) begin
              phase = PH_REGADR;
              cnt = '0;
            end
          end
          PH_REGADR: begin
            drv = 1'b1;
            lvl = f_reg[3'd4 - cnt[2:0]];
            cnt++;
            if (cnt >= mmia_pkg::ADDR_BITS) begin
              phase = f_rd ? PH_TA_RD : PH_TA_WR;
              cnt = '0;
            end
          end
          PH_TA_WR: begin
            drv = 1'b1;
            lvl = (cnt == '0);
            cnt++;
            if (cnt >= mmia_pkg::TA_BITS) begin
              phase = PH_WDATA;
              cnt = '0;
            end
          end
          PH_WDATA: begin
            drv = 1'b1;
            lvl = shreg[15];
            shreg = shreg << 1;
            cnt++;
            if (cnt >= mmia_pkg::DATA_BITS) begin
              phase = PH_WIDLE;
              cnt = '0;
            end
          end
          PH_WIDLE: begin
            drv = 1'b1;
            lvl = 1'b1;
            fin = 1'b1;
          end
          PH_TA_RD: begin
            cnt = '0;
            // a high turnaround means no phy answered
            if (it.mdio_in) begin
              err = 1'b1;
              phase = PH_FLUSH;
            end else begin
              capture = '0;
              phase = PH_RDATA;
            end
          end
          PH_FLUSH: begin
            cnt++;
            if (cnt >= mmia_pkg::FLUSH_TICKS) begin
              capture = mmia_pkg::VAL_FAIL;
              fin = 1'b1;
            end
          end
          PH_RDATA: begin
            capture = {capture[14:0], it.mdio_in};
            cnt++;
            if (cnt >= mmia_pkg::DATA_BITS) begin
              phase = PH_RIDLE;
              cnt = '0;
            end
          end
          PH_RIDLE: fin = 1'b1;
          default: begin
            phase = PH_IDLE;
            busy = 1'b0;
          end
        endcase
        if (fin) begin
          if (f_last) begin
            r.done = 1'b1;
            r.read_value = f_rd ? capture : '0;
            r.ta_error = err;
            busy = 1'b0;
            phase = PH_IDLE;
            cnt = '0;
          end else begin
            idx++;
            start_frame();
          end
        end
      end
      r.mdio_level = drv & lvl;
      r.mdio_drive = drv;
      r.busy = busy;
      return r;
    endfunction

    function void note_input(mdio_item_t it);
      due_results.push_back(predict_tick(it));
    endfunction

    task report(string what);
      $display("mdio mismatch at result %0d: %s", seen, what);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(mdio_result_t got);
      mdio_result_t want;
      seen++;
      if (due_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        want = due_results.pop_front();
        compare_field("mdio_level", 16'(got.mdio_level), 16'(want.mdio_level));
        compare_field("mdio_drive", 16'(got.mdio_drive), 16'(want.mdio_drive));
        compare_field("busy_res", 16'(got.busy), 16'(want.busy));
        compare_field("done_res", 16'(got.done), 16'(want.done));
        compare_field("read_value", got.read_value, want.read_value);
        compare_field("ta_error", 16'(got.ta_error), 16'(want.ta_error));
        compare_field("cmd_rejected", 16'(got.rejected), 16'(want.rejected));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_req_type = 1'b0;
  logic [1:0]  in_op = '0;
  logic [4:0]  in_phy_addr = '0;
  logic [15:0] in_reg_addr = '0;
  logic [15:0] in_wr_data = '0;
  logic        in_mdio_in = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_mdio_level;
  logic        out_mdio_drive;
  logic        out_busy_res;
  logic        out_done_res;
  logic [15:0] out_read_value;
  logic        out_ta_error;
  logic        out_cmd_rejected;

  logic in_calm = 1'b0;
  logic out_calm = 1'b0;
  int   quiet = 0;
  int   frame_items = 0;
  mdio_frame_scoreboard board;

  always #1 clk = ~clk;

  mdio_master_indirect_access i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_op            (in_op),
    .in_phy_addr      (in_phy_addr),
    .in_reg_addr      (in_reg_addr),
    .in_wr_data       (in_wr_data),
    .in_mdio_in       (in_mdio_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mdio_level   (out_mdio_level),
    .out_mdio_drive   (out_mdio_drive),
    .out_busy_res     (out_busy_res),
    .out_done_res     (out_done_res),
    .out_read_value   (out_read_value),
    .out_ta_error     (out_ta_error),
    .out_cmd_rejected (out_cmd_rejected)
  );

  // one transfer on the input side; returns right after the accepting edge
  task automatic send_item(input mdio_item_t it);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req_type;
    in_op <= it.op;
    in_phy_addr <= it.phy;
    in_reg_addr <= it.reg_addr;
    in_wr_data <= it.wr_data;
    in_mdio_in <= it.mdio_in;
    do @(posedge clk); while (!(in_valid && !in_stall));
    board.note_input(it);
  endtask

  task automatic send_command(input logic [1:0] op, input logic [4:0] phy,
                              input logic [15:0] addr, input logic [15:0] data);
    mdio_item_t it;
    it.req_type = REQ_CMD;
    it.op = op;
    it.phy = phy;
    it.reg_addr = addr;
    it.wr_data = data;
    it.mdio_in = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // unused command fields carry random noise on a tick
  task automatic send_tick(input logic mdin);
    mdio_item_t it;
    it.req_type = REQ_TICK;
    it.op = 2'($urandom);
    it.phy = 5'($urandom);
    it.reg_addr = 16'($urandom);
    it.wr_data = 16'($urandom);
    it.mdio_in = mdin;
    send_item(it);
  endtask

  // one command followed by ticks, with rejected commands mixed in, until the last frame completes
  task automatic run_transaction(input logic [1:0] op, input logic [4:0] phy,
                                 input logic [15:0] addr, input logic [15:0] data,
                                 input logic ta_bit, input int rd_bits, input int reject_pct);
    logic mdin;
    send_command(op, phy, addr, data);
    frame_items++;
    while (board.busy) begin
      if (int'($urandom_range(0, 99)) < reject_pct) begin
        send_command(2'($urandom), 5'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        if (board.phase == PH_TA_RD) mdin = ta_bit;
        else if (rd_bits == MDIN_RANDOM) mdin = 1'($urandom_range(0, 1));
        else mdin = 1'(rd_bits);
        send_tick(mdin);
        frame_items++;
      end
    end
  endtask

  // result side: check each transfer, then hold off for a drawn number of cycles
  initial begin
    int hold;
    mdio_result_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.mdio_level = out_mdio_level;
        got.mdio_drive = out_mdio_drive;
        got.busy = out_busy_res;
        got.done = out_done_res;
        got.read_value = out_read_value;
        got.ta_error = out_ta_error;
        got.rejected = out_cmd_rejected;
        board.check_result(got);
        hold = out_calm ? 0 : $urandom_range(0, 5);
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("mdio_master_indirect_access_test NOT OK");
      $finish;
    end
  end

  initial begin
    logic [1:0] op;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle ticks, every op with field extremes among the values, failed turnaround, rejects
    send_tick(1'b0);
    send_tick(1'b1);
    run_transaction(mmia_pkg::OP_RD_DIRECT, 5'h00, 16'h0000, 16'h0000, 1'b0, 0, 0);
    run_transaction(mmia_pkg::OP_RD_DIRECT, 5'h1F, 16'hFFFF, 16'hFFFF, 1'b1, MDIN_RANDOM, 0);
    run_transaction(mmia_pkg::OP_RD_DIRECT, 5'h0A, 16'h0015, 16'h1234, 1'b0, 1, 0);
    run_transaction(mmia_pkg::OP_WR_DIRECT, 5'h1F, 16'h001F, 16'hFFFF, 1'b0, MDIN_RANDOM, 0);
    run_transaction(mmia_pkg::OP_WR_DIRECT, 5'h00, 16'hFFE0, 16'h0000, 1'b0, MDIN_RANDOM, 20);
    run_transaction(mmia_pkg::OP_RD_INDIR, 5'h15, 16'hFFFF, 16'h0000, 1'b0, 1, 0);
    run_transaction(mmia_pkg::OP_RD_INDIR, 5'h0A, 16'h0000, 16'hFFFF, 1'b1, 0, 0);
    run_transaction(mmia_pkg::OP_WR_INDIR, 5'h1F, 16'h0000, 16'hFFFF, 1'b0, MDIN_RANDOM, 0);
    run_transaction(mmia_pkg::OP_WR_INDIR, 5'h00, 16'hFFFF, 16'h0000, 1'b0, MDIN_RANDOM, 5);
    send_tick(1'b1);

    // random: mostly complete transactions, some idle ticks and rejected commands
    while (frame_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_tick(1'($urandom));
      if ($urandom_range(0, 9) < 6) begin
        op = $urandom_range(0, 1) ? mmia_pkg::OP_WR_DIRECT : mmia_pkg::OP_RD_DIRECT;
      end else begin
        op = $urandom_range(0, 1) ? mmia_pkg::OP_WR_INDIR : mmia_pkg::OP_RD_INDIR;
      end
      run_transaction(op, 5'($urandom), 16'($urandom), 16'($urandom),
                      1'($urandom_range(0, 3) == 0), MDIN_RANDOM, 3);
    end
    in_valid <= 1'b0;

    while (board.due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("mdio_master_indirect_access_test OK");
    end else begin
      $display("mdio_master_indirect_access_test NOT OK");
    end
    $finish;
  end

endmodule
